// ----- rtl/fe_pkg.sv -----
// ----------------------------------------------------------------------------
// fe_pkg
// shared types, fixed-point constants and the arctangent table for the
// fisheye to equirectangular coordinate map
// ----------------------------------------------------------------------------
`default_nettype none

package fe_pkg;

    // default sizes
    localparam int MAX_DIM_DEF       = 1024;
    localparam int CORDIC_STAGES_DEF = 16;

    // datapath width for angles and unit vectors (Q16)
    localparam int DW        = 24;
    localparam int DIM_W     = 11;
    localparam int PIX_W     = 10;
    localparam int FIELD_LIM = 1024;

    localparam logic signed [18:0]   PI_S      = 19'sd205887;
    localparam logic signed [DW-1:0] HALF_PI_S = 24'sd102944;
    localparam logic signed [DW-1:0] KINV_S    = 24'sd39797;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd610;

    // register map
    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] out_col;
        logic [PIX_W-1:0] out_row;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] src_col;
        logic [PIX_W-1:0] src_row;
        logic             src_valid;
    } t_result;

    // atan(2^-i) in Q16, rounded to nearest
    function automatic logic signed [DW-1:0] atan_q(input int idx);
        logic signed [DW-1:0] val;
        case (idx)
            0:       val = 24'sd51472;
            1:       val = 24'sd30386;
            2:       val = 24'sd16055;
            3:       val = 24'sd8150;
            4:       val = 24'sd4091;
            5:       val = 24'sd2047;
            6:       val = 24'sd1024;
            7:       val = 24'sd512;
            8:       val = 24'sd256;
            9:       val = 24'sd128;
            10:      val = 24'sd64;
            11:      val = 24'sd32;
            12:      val = 24'sd16;
            13:      val = 24'sd8;
            14:      val = 24'sd4;
            15:      val = 24'sd2;
            16:      val = 24'sd1;
            default: val = 24'sd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fe_div.sv -----
// ----------------------------------------------------------------------------
// fe_div
// pipelined restoring divider, one quotient bit per cell, with a side tag
// ----------------------------------------------------------------------------
`default_nettype none

module fe_div
    import fe_pkg::*;
#(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11,
    parameter int QUO_W = 16,
    parameter int TAG_W = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo,
    output logic [TAG_W-1:0]      o_tag
);

    logic             r_v   [0:QUO_W];
    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_num [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic [TAG_W-1:0] r_tag [0:QUO_W];

    // the upper dividend bits start as the partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]);
        r_num[0] <= i_num[QUO_W-1:0];
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_tag[0] <= i_tag;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] n_rem;

        always_comb begin
            trial = {r_rem[k], r_num[k][QUO_W-1-k]};
            ge    = (trial >= {1'b0, r_den[k]});
            n_rem = ge ? DEN_W'(trial - {1'b0, r_den[k]}) : DEN_W'(trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_num[k+1] <= r_num[k];
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][QUO_W-2:0], ge};
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_v[QUO_W];
    assign o_quo   = r_q[QUO_W];
    assign o_tag   = r_tag[QUO_W];

endmodule

`default_nettype wire

// ----- rtl/fe_cordic.sv -----
// ----------------------------------------------------------------------------
// fe_cordic
// pipelined cordic, rotation or vectoring mode, one micro-rotation per cell
// ----------------------------------------------------------------------------
`default_nettype none

module fe_cordic
    import fe_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b0,
    parameter int TAG_W  = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [DW-1:0] i_x,
    input  wire logic signed [DW-1:0] i_y,
    input  wire logic signed [DW-1:0] i_z,
    input  wire logic [TAG_W-1:0]     i_tag,
    output logic                      o_valid,
    output logic signed [DW-1:0]      o_x,
    output logic signed [DW-1:0]      o_y,
    output logic signed [DW-1:0]      o_z,
    output logic [TAG_W-1:0]          o_tag
);

    logic                 r_v    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic signed [DW-1:0] r_x    [0:STAGES];
    logic signed [DW-1:0] r_y    [0:STAGES];
    logic signed [DW-1:0] r_z    [0:STAGES];
    logic [TAG_W-1:0]     r_tag  [0:STAGES];

    logic                 n_zero;
    logic signed [DW-1:0] n_x, n_y, n_z;

    // vectoring folds the left half plane by a quarter turn
    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_z    = i_z;
        n_zero = 1'b0;
        if (VECTOR) begin
            n_z    = '0;
            n_zero = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x = i_y;
                    n_y = -i_x;
                    n_z = HALF_PI_S;
                end else begin
                    n_x = -i_y;
                    n_y = i_x;
                    n_z = -HALF_PI_S;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= n_zero;
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
        r_tag[0]  <= i_tag;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        logic signed [DW-1:0] dx, dy;
        logic                 up;

        always_comb begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            up = VECTOR ? r_y[i][DW-1] : ~r_z[i][DW-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (up) begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_q(i);
            end else begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_q(i);
            end
            r_zero[i+1] <= r_zero[i];
            r_tag[i+1]  <= r_tag[i];
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_x     = r_x[STAGES];
    assign o_y     = r_y[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_tag   = r_tag[STAGES];

endmodule

`default_nettype wire

// ----- rtl/fisheye_to_equirect_coordinate_map.sv -----
// ----------------------------------------------------------------------------
// fisheye_to_equirect_coordinate_map
// maps an equirectangular output pixel to its 180-degree fisheye source pixel
// ----------------------------------------------------------------------------
// usage:
//   command channel: drive i_cmd and raise start; the transfer happens at a
//   clock edge with start high and busy low. busy stays low, so one pixel
//   can be issued every cycle, as a raster scan does.
//   result channel: o_valid marks o_result for exactly one cycle; the
//   receiver takes it then and cannot stall the pipeline.
//   config: apb writes at 0x0 (image width) and 0x4 (image height), always
//   ready, readable; write them only while no pixel is in flight.
// timing:
//   fully pipelined, one pixel per cycle; the pipeline runs through the two
//   16-bit divider chains for col/W and row/H, three cordic chains (two
//   pairs run side by side) and a registered reciprocal multiply for b/pi.
// reset:
//   clears every pipeline valid bit and loads both dimensions with 610;
//   results come back in issue order.
// ----------------------------------------------------------------------------
`default_nettype none

module fisheye_to_equirect_coordinate_map
    import fe_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_cmd,
    output logic             o_valid,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] w, h;
    t_reg_idx         reg_sel;

    assign reg_sel = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign w = (int'(r_width)  > MAX_DIM) ? DIM_W'(MAX_DIM) : r_width;
    assign h = (int'(r_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_height;

    // ---------------- p0: command register ----------------
    logic             r0_v, r0_ok;
    logic [PIX_W-1:0] r0_col, r0_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_col <= i_cmd.out_col;
        r0_row <= i_cmd.out_row;
        r0_ok  <= (w != '0) && (h != '0) &&
                  ({1'b0, i_cmd.out_col} < w) && ({1'b0, i_cmd.out_row} < h);
    end

    // ---------------- col/W and row/H in Q16 ----------------
    logic        dc_v, dc_ok, dr_v;
    logic [15:0] fc, fr;
    logic [0:0]  dr_tag;

    fe_div #(.NUM_W(PIX_W + 16), .DEN_W(DIM_W), .QUO_W(16), .TAG_W(1)) u_div_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_v),
        .i_num   ({r0_col, 16'd0}),
        .i_den   (w),
        .i_tag   (r0_ok),
        .o_valid (dc_v),
        .o_quo   (fc),
        .o_tag   (dc_ok)
    );

    fe_div #(.NUM_W(PIX_W + 16), .DEN_W(DIM_W), .QUO_W(16), .TAG_W(1)) u_div_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_v),
        .i_num   ({r0_row, 16'd0}),
        .i_den   (h),
        .i_tag   (1'b0),
        .o_valid (dr_v),
        .o_quo   (fr),
        .o_tag   (dr_tag)
    );

    // ---------------- p1/p2: angles, truncated toward zero ----------------
    logic                 r1_v, r1_ok, r2_v, r2_ok;
    logic signed [36:0]   r1_pth, r1_pph;
    logic signed [DW-1:0] r2_th, r2_ph;
    logic signed [17:0]   dth, dph;

    assign dth = $signed({2'b00, fc}) - 18'sd32768;
    assign dph = $signed({2'b00, fr}) - 18'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= dc_v && dr_v;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok  <= dc_ok && !dr_tag[0];
        r1_pth <= 37'(PI_S) * 37'(dth);
        r1_pph <= 37'(PI_S) * 37'(dph);
        r2_ok  <= r1_ok;
        r2_th  <= DW'((r1_pth + (r1_pth < 0 ? 37'sd65535 : 37'sd0)) >>> 16);
        r2_ph  <= DW'((r1_pph + (r1_pph < 0 ? 37'sd65535 : 37'sd0)) >>> 16);
    end

    // ---------------- cos/sin of theta and phi ----------------
    logic                 rt_v, rt_ok, rp_v, rp_tag;
    logic signed [DW-1:0] ct, st, cp, sp, rt_z, rp_z;

    fe_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_th (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_x     (KINV_S),
        .i_y     ('0),
        .i_z     (r2_th),
        .i_tag   (r2_ok),
        .o_valid (rt_v),
        .o_x     (ct),
        .o_y     (st),
        .o_z     (rt_z),
        .o_tag   (rt_ok)
    );

    fe_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_ph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_x     (KINV_S),
        .i_y     ('0),
        .i_z     (r2_ph),
        .i_tag   (1'b0),
        .o_valid (rp_v),
        .o_x     (cp),
        .o_y     (sp),
        .o_z     (rp_z),
        .o_tag   (rp_tag)
    );

    // ---------------- p3: direction vector ----------------
    logic                 r3_v, r3_ok;
    logic signed [47:0]   r3_px, r3_py;
    logic signed [DW-1:0] r3_z, vx, vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= rt_v && rp_v;
        end
    end

    // leftover angles are not needed beyond the rotation
    always_ff @(posedge i_clk) begin
        r3_ok <= rt_ok && !rp_tag && (rt_z == rt_z) && (rp_z == rp_z);
        r3_px <= 48'(cp) * 48'(st);
        r3_py <= 48'(cp) * 48'(ct);
        r3_z  <= sp;
    end

    assign vx = DW'(r3_px >>> 16);
    assign vy = DW'(r3_py >>> 16);

    // ---------------- a = atan2(z, x), |(x, z)| ----------------
    logic                 v1_v;
    logic signed [DW-1:0] v1_x, v1_y, v1_a;
    logic [DW:0]          v1_tag;

    fe_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .TAG_W(DW + 1)) u_vec_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_x     (vx),
        .i_y     (r3_z),
        .i_z     ('0),
        .i_tag   ({r3_ok, vy}),
        .o_valid (v1_v),
        .o_x     (v1_x),
        .o_y     (v1_y),
        .o_z     (v1_a),
        .o_tag   (v1_tag)
    );

    // ---------------- p5: magnitude gain correction ----------------
    logic                 r5_v, r5_ok;
    logic signed [47:0]   r5_mag;
    logic signed [DW-1:0] r5_a, r5_y, r5_r, fa;
    logic                 fneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= v1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_ok  <= v1_tag[DW] && (v1_y == v1_y);
        r5_y   <= $signed(v1_tag[DW-1:0]);
        r5_a   <= v1_a;
        r5_mag <= 48'(v1_x) * 48'(KINV_S);
    end

    assign r5_r = DW'(r5_mag >>> 16);

    // fold a into the half plane the rotation covers
    always_comb begin
        fa   = r5_a;
        fneg = 1'b0;
        if (r5_a > HALF_PI_S) begin
            fa   = r5_a - DW'(PI_S);
            fneg = 1'b1;
        end else if (r5_a < -HALF_PI_S) begin
            fa   = r5_a + DW'(PI_S);
            fneg = 1'b1;
        end
    end

    // ---------------- b = atan2(r, y) and cos/sin of a ----------------
    logic                 v2_v, v2_ok, ra_v, ra_neg;
    logic signed [DW-1:0] v2_x, v2_y, v2_b, ca, sa, ra_z;

    fe_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1), .TAG_W(1)) u_vec_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_x     (r5_y),
        .i_y     (r5_r),
        .i_z     ('0),
        .i_tag   (r5_ok),
        .o_valid (v2_v),
        .o_x     (v2_x),
        .o_y     (v2_y),
        .o_z     (v2_b),
        .o_tag   (v2_ok)
    );

    fe_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_x     (KINV_S),
        .i_y     ('0),
        .i_z     (fa),
        .i_tag   (fneg),
        .o_valid (ra_v),
        .o_x     (ca),
        .o_y     (sa),
        .o_z     (ra_z),
        .o_tag   (ra_neg)
    );

    // ---------------- p6: |b| and signed cos/sin ----------------
    logic                 r6_v, r6_ok, r6_bneg;
    logic [18:0]          r6_babs;
    logic signed [DW-1:0] r6_ca, r6_sa, babs;

    assign babs = v2_b[DW-1] ? -v2_b : v2_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= v2_v && ra_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_ok   <= v2_ok && (v2_x == v2_x) && (v2_y == v2_y) && (ra_z == ra_z);
        r6_bneg <= v2_b[DW-1];
        r6_babs <= babs[18:0];
        r6_ca   <= ra_neg ? -ca : ca;
        r6_sa   <= ra_neg ? -sa : sa;
    end

    // ---------------- b/pi in Q16 ----------------
    // 2^49 / PI_S rounded up; floor(|b| * m / 2^33) is exact for |b| below 2^18
    localparam int          BT_W     = 2 + 2 * DW;
    localparam logic [31:0] INV_PI_M = 32'd2734266629;

    logic            r_db_v;
    logic [50:0]     r_bprod;
    logic [17:0]     bq;
    logic [BT_W-1:0] r_db_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_v <= 1'b0;
        end else begin
            r_db_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bprod  <= 51'(r6_babs) * 51'(INV_PI_M);
        r_db_tag <= {r6_ok, r6_bneg, r6_ca, r6_sa};
    end

    assign bq = r_bprod[50:33];

    // ---------------- p7..p9: scale and offset ----------------
    logic                 r7_v, r7_ok, r8_v, r8_ok, r9_v, r9_ok;
    logic signed [18:0]   bn;
    logic signed [30:0]   r7_wb, r7_hb;
    logic signed [DW-1:0] r7_ca, r7_sa;
    logic signed [54:0]   r8_mx, r8_my;
    logic signed [39:0]   r9_qx, r9_qy;
    logic signed [38:0]   tx, ty;

    assign bn = r_db_tag[BT_W-2] ? -$signed({1'b0, bq}) : $signed({1'b0, bq});
    assign tx = 39'((r8_mx + (r8_mx < 0 ? 55'sd65535 : 55'sd0)) >>> 16);
    assign ty = 39'((r8_my + (r8_my < 0 ? 55'sd65535 : 55'sd0)) >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else begin
            r7_v <= r_db_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_ok <= r_db_tag[BT_W-1];
        r7_ca <= $signed(r_db_tag[2*DW-1:DW]);
        r7_sa <= $signed(r_db_tag[DW-1:0]);
        r7_wb <= 31'($signed({1'b0, w})) * 31'(bn);
        r7_hb <= 31'($signed({1'b0, h})) * 31'(bn);
        r8_ok <= r7_ok;
        r8_mx <= 55'(r7_wb) * 55'(r7_ca);
        r8_my <= 55'(r7_hb) * 55'(r7_sa);
        r9_ok <= r8_ok;
        r9_qx <= $signed({13'd0, w, 16'd0}) / 2 + 40'(tx);
        r9_qy <= $signed({13'd0, h, 16'd0}) / 2 + 40'(ty);
    end

    // ---------------- p10: pixel and range check ----------------
    logic signed [23:0] px, py;
    logic               in_x, in_y;
    t_result            r_result;
    logic               r_valid;

    assign px   = 24'((r9_qx + (r9_qx < 0 ? 40'sd65535 : 40'sd0)) >>> 16);
    assign py   = 24'((r9_qy + (r9_qy < 0 ? 40'sd65535 : 40'sd0)) >>> 16);
    assign in_x = (px >= 0) && (px < $signed({13'd0, w})) && (px < 24'sd1024);
    assign in_y = (py >= 0) && (py < $signed({13'd0, h})) && (py < 24'sd1024);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r9_ok && in_x && in_y) begin
            r_result.src_col   <= px[PIX_W-1:0];
            r_result.src_row   <= py[PIX_W-1:0];
            r_result.src_valid <= 1'b1;
        end else begin
            r_result <= '0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
